### rtl/core/sie_pkg.sv
// ----------------------------------------------------------------------------
// sie_pkg: shared types and constants of the set intersection engine
// Holds the hash multiplier, the queued command type and the engine states.
// ----------------------------------------------------------------------------
package sie_pkg;

  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

  // one classified beat waiting between front and back
  typedef struct packed {
    logic [31:0] key;
    logic        query;
    logic        last;
  } sie_cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_EMIT
  } sie_state_t;

endpackage

### rtl/core/sie_front.sv
// ----------------------------------------------------------------------------
// sie_front: input stage and command queue
// Accepts beats, tags them as insert or query and queues them for the back end.
// ----------------------------------------------------------------------------
module sie_front #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_key,
  input  logic                in_from_second,
  input  logic                in_last,
  output logic                cmd_valid,
  output sie_pkg::sie_cmd_t   cmd,
  input  logic                cmd_take
);
  import sie_pkg::*;

  localparam int AW = $clog2(DEPTH);

  sie_cmd_t          q_r [DEPTH];
  logic [AW-1:0]     wp_r, rp_r;
  logic [AW:0]       cnt_r;
  logic              push, pop;

  assign in_stall  = (cnt_r == (AW+1)'(DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_take && cmd_valid;
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{key: in_key, query: in_from_second,
                     last: in_from_second & in_last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

### rtl/core/sie_back.sv
// ----------------------------------------------------------------------------
// sie_back: hash table engine
// Probes the key memory linearly, inserts, marks reports and builds results.
// ----------------------------------------------------------------------------
module sie_back #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  sie_pkg::sie_cmd_t   cmd,
  output logic                cmd_take,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_common_key,
  output logic                out_has_key,
  output logic                out_end_of_set,
  output logic                out_table_full
);
  import sie_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);

  // key memory: one read port, one write port
  logic [31:0]   keys_mem [TABLE_ENTRIES];
  // flag memory: bit1 valid, bit0 reported; zeroed by a sweep
  logic [1:0]    flag_mem [TABLE_ENTRIES];

  sie_state_t    st_r, st_nxt;
  sie_cmd_t      c_r;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [AW:0]   seen_r, seen_nxt;
  logic [31:0]   rkey_r;
  logic [1:0]    rflag_r;
  logic          ovf_r, ovf_nxt;
  logic [31:0]   prod_r;

  logic          kw_en, fw_en;
  logic [1:0]    fw_data;
  logic [AW-1:0] fw_addr;

  logic          ov_r, ov_nxt;
  logic [31:0]   ok_r, ok_nxt;
  logic          oh_r, oh_nxt, oe_r, oe_nxt, of_r, of_nxt;
  logic          is_hit, is_free;

  assign is_free = !rflag_r[1];
  assign is_hit  = rflag_r[1] && (rkey_r == c_r.key);

  always_ff @(posedge clk) begin
    if (kw_en) keys_mem[slot_r] <= c_r.key;
    if (fw_en) flag_mem[fw_addr] <= fw_data;
    rkey_r  <= keys_mem[slot_nxt];
    rflag_r <= flag_mem[slot_nxt];
  end

  // hash the key as it is taken, so the product is ready in ST_HASH
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      c_r    <= cmd;
      prod_r <= cmd.key * HASH_MULT;
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: if (slot_r == AW'(TABLE_ENTRIES-1)) st_nxt = ST_IDLE;
      ST_IDLE:  if (cmd_valid && !ov_r) st_nxt = ST_HASH;
      ST_HASH:  st_nxt = ST_READ;
      ST_READ:  st_nxt = ST_CHECK;
      ST_CHECK: begin
        if (is_free || is_hit || seen_r == (AW+1)'(TABLE_ENTRIES-1)) begin
          st_nxt = ST_EMIT;
        end else begin
          st_nxt = ST_READ;
        end
      end
      ST_EMIT:  st_nxt = (c_r.last && !ov_r) ? ST_CLEAR : ST_IDLE;
      default:  st_nxt = ST_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cmd_take = 1'b0;
    slot_nxt = slot_r;
    seen_nxt = seen_r;
    ovf_nxt  = ovf_r;
    kw_en    = 1'b0;
    fw_en    = 1'b0;
    fw_addr  = slot_r;
    fw_data  = 2'b00;
    ov_nxt   = ov_r && out_stall;
    ok_nxt   = ok_r;
    oh_nxt   = oh_r;
    oe_nxt   = oe_r;
    of_nxt   = of_r;
    case (st_r)
      ST_CLEAR: begin
        fw_en    = 1'b1;
        slot_nxt = slot_r + 1'b1;
        ovf_nxt  = 1'b0;
      end
      ST_IDLE: begin
        cmd_take = cmd_valid && !ov_r;
        slot_nxt = '0;
      end
      ST_HASH: begin
        // home slot: low bits of the product, hence linear wrap by overflow
        slot_nxt = prod_r[AW-1:0];
        seen_nxt = '0;
      end
      ST_READ: ;
      ST_CHECK: begin
        if (!(is_free || is_hit || seen_r == (AW+1)'(TABLE_ENTRIES-1))) begin
          slot_nxt = slot_r + 1'b1;
          seen_nxt = seen_r + 1'b1;
        end
      end
      ST_EMIT: begin
        // no step back needed: the probed slot is still slot_r (state reached from CHECK)
        if (!c_r.query) begin
          if (is_free) begin
            kw_en   = 1'b1;
            fw_en   = 1'b1;
            fw_data = 2'b10;
          end else if (!is_hit) begin
            ovf_nxt = 1'b1;
          end
        end else begin
          if (is_hit && !rflag_r[0]) begin
            fw_en   = 1'b1;
            fw_data = 2'b11;
          end
          if ((is_hit && !rflag_r[0]) || c_r.last) begin
            ov_nxt = 1'b1;
            oh_nxt = is_hit && !rflag_r[0];
            ok_nxt = (is_hit && !rflag_r[0]) ? c_r.key : '0;
            oe_nxt = c_r.last;
            of_nxt = ovf_r;
          end
          if (c_r.last) slot_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLEAR;
      slot_r <= '0;
      seen_r <= '0;
      ovf_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      slot_r <= slot_nxt;
      seen_r <= seen_nxt;
      ovf_r  <= ovf_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= ok_nxt;
    oh_r <= oh_nxt;
    oe_r <= oe_nxt;
    of_r <= of_nxt;
  end

  assign out_valid      = ov_r;
  assign out_common_key = ok_r;
  assign out_has_key    = oh_r;
  assign out_end_of_set = oe_r;
  assign out_table_full = of_r;

endmodule

### rtl/core/set_intersection_engine.sv
// ----------------------------------------------------------------------------
// set_intersection_engine: hash set intersection of two key lists
// First-list keys fill a linear-probe hash table, second-list keys query it.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | in_key, in_from_second, in_last
//  out     | out_valid/out_stall| out_common_key, out_has_key, out_end_of_set,
//          |                    | out_table_full
//
// An item passes ST_HASH, ST_READ, ST_CHECK and ST_EMIT; each extra probe step repeats
// ST_READ and ST_CHECK: the single read port of the key memory sets the pace of the
// probe loop. A small queue takes beats while the engine works. After reset, and
// after each closing beat, the flag memory is swept; queued beats wait meanwhile.
// A waiting result holds the engine until out_stall drops.
// ----------------------------------------------------------------------------
module set_intersection_engine #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_key,
  input  logic               in_from_second,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_common_key,
  output logic               out_has_key,
  output logic               out_end_of_set,
  output logic               out_table_full
);
  import sie_pkg::*;

  sie_cmd_t cmd;
  logic     cmd_valid, cmd_take;

  // front: accept and classify, hold in the queue
  sie_front #(.DEPTH(4)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_key, .in_from_second, .in_last,
    .cmd_valid, .cmd, .cmd_take
  );

  // back: probe, update the table and drive results
  sie_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take,
    .out_valid, .out_stall, .out_common_key, .out_has_key,
    .out_end_of_set, .out_table_full
  );

endmodule
